FILE: rtl/arpf_pkg.sv
// shared types, constants and arithmetic helpers for the axis rotation block
`timescale 1ns / 1ps
package arpf_pkg;

   localparam int SQ_STEPS = 31;
   localparam int DV_STEPS = 31;

   localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;
   localparam logic signed [31:0] ONE_Q30_N = -32'sh4000_0000;
   localparam logic signed [39:0] GUARD_P   = 40'sd8589934591;
   localparam logic signed [39:0] GUARD_N   = -40'sd8589934591;
   localparam logic signed [65:0] RND_HALF  = 66'sd536870912;
   localparam logic signed [39:0] OUT_MAX   = 40'sd2147483647;
   localparam logic signed [39:0] OUT_MIN   = -40'sd2147483648;

   typedef enum logic {
      ACT_PLACE = 1'b0,
      ACT_FORCE = 1'b1
   } action_type;

   typedef struct packed {
      logic             action;
      logic             degen;
      logic [2:0][31:0] st;
      logic [2:0][31:0] vec;
      logic [31:0]      c;
      logic [31:0]      s;
   } ctx_type;

   typedef struct packed {
      ctx_type          ctx;
      logic [2:0]       dneg;
      logic [2:0][29:0] dmag;
   } side_type;

   function automatic logic [31:0] clamp_trig(input logic signed [31:0] x);
      logic [31:0] r;
      if (x > ONE_Q30) begin
         r = ONE_Q30;
      end else if (x < ONE_Q30_N) begin
         r = ONE_Q30_N;
      end else begin
         r = x;
      end
      return r;
   endfunction

   function automatic logic signed [65:0] mulq_raw(input logic signed [31:0] a,
                                                   input logic signed [33:0] b);
      logic signed [65:0] p;
      p = a * b;
      return p;
   endfunction

   // round half up back to q16.16
   function automatic logic signed [35:0] rnd(input logic signed [65:0] p);
      logic signed [65:0] q;
      q = p + RND_HALF;
      return q[65:30];
   endfunction

   function automatic logic signed [33:0] clamp34(input logic signed [39:0] x);
      logic signed [33:0] r;
      if (x > GUARD_P) begin
         r = GUARD_P[33:0];
      end else if (x < GUARD_N) begin
         r = GUARD_N[33:0];
      end else begin
         r = x[33:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/arpf_norm.sv
// axis difference, scaling to a fixed range and sum of squares
`timescale 1ns / 1ps
module arpf_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  arpf_pkg::ctx_type     in_ctx,
   input  logic [2:0][31:0]      in_end,
   output logic                  out_valid,
   output arpf_pkg::side_type    out_side,
   output logic [61:0]           out_sum
);

   // stage 1
   logic              s1_vld_ff;
   arpf_pkg::ctx_type s1_ctx_ff, s1_ctx_in;
   logic [2:0]        s1_neg_ff, s1_neg_in;
   logic [2:0][32:0]  s1_abs_ff, s1_abs_in;
   logic [32:0]       s1_max_ff, s1_max_in;

   always_comb begin
      logic signed [32:0] d;
      s1_ctx_in   = in_ctx;
      s1_ctx_in.c = arpf_pkg::clamp_trig($signed(in_ctx.c));
      s1_ctx_in.s = arpf_pkg::clamp_trig($signed(in_ctx.s));
      s1_max_in   = '0;
      for (int i = 0; i < 3; i++) begin
         d = $signed({in_end[i][31], in_end[i]}) - $signed({in_ctx.st[i][31], in_ctx.st[i]});
         s1_neg_in[i] = d[32];
         s1_abs_in[i] = d[32] ? 33'(-d) : 33'(d);
         if (s1_abs_in[i] > s1_max_in) begin
            s1_max_in = s1_abs_in[i];
         end
      end
      s1_ctx_in.degen = (s1_max_in == '0);
   end

   // stage 2: shift so the largest magnitude lands in [2^29, 2^30)
   logic              s2_vld_ff;
   arpf_pkg::side_type s2_side_ff, s2_side_in;

   always_comb begin
      logic [5:0]  p;
      logic [32:0] t;
      p = '0;
      for (int b = 0; b < 33; b++) begin
         if (s1_max_ff[b]) begin
            p = 6'(b);
         end
      end
      s2_side_in.ctx  = s1_ctx_ff;
      s2_side_in.dneg = s1_neg_ff;
      for (int i = 0; i < 3; i++) begin
         if (p >= 6'd30) begin
            t = s1_abs_ff[i] >> (p - 6'd29);
         end else begin
            t = s1_abs_ff[i] << (6'd29 - p);
         end
         s2_side_in.dmag[i] = t[29:0];
      end
   end

   // stage 3: squares, stage 4: sum
   logic               s3_vld_ff;
   arpf_pkg::side_type s3_side_ff;
   logic [2:0][59:0]   s3_sq_ff;
   logic               s4_vld_ff;
   arpf_pkg::side_type s4_side_ff;
   logic [61:0]        s4_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
      s1_ctx_ff  <= s1_ctx_in;
      s1_neg_ff  <= s1_neg_in;
      s1_abs_ff  <= s1_abs_in;
      s1_max_ff  <= s1_max_in;
      s2_side_ff <= s2_side_in;
      s3_side_ff <= s2_side_ff;
      for (int i = 0; i < 3; i++) begin
         s3_sq_ff[i] <= 60'(s2_side_ff.dmag[i]) * 60'(s2_side_ff.dmag[i]);
      end
      s4_side_ff <= s3_side_ff;
      s4_sum_ff  <= 62'(s3_sq_ff[0]) + 62'(s3_sq_ff[1]) + 62'(s3_sq_ff[2]);
   end

   assign out_valid = s4_vld_ff;
   assign out_side  = s4_side_ff;
   assign out_sum   = s4_sum_ff;

endmodule

FILE: rtl/arpf_sqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module arpf_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  arpf_pkg::side_type in_side,
   input  logic [61:0]        in_rad,
   output logic               out_valid,
   output arpf_pkg::side_type out_side,
   output logic [30:0]        out_root
);

   logic               vld_ff  [arpf_pkg::SQ_STEPS];
   arpf_pkg::side_type side_ff [arpf_pkg::SQ_STEPS];
   logic [61:0]        rad_ff  [arpf_pkg::SQ_STEPS];
   logic [33:0]        rem_ff  [arpf_pkg::SQ_STEPS];
   logic [30:0]        root_ff [arpf_pkg::SQ_STEPS];

   for (genvar g = 0; g < arpf_pkg::SQ_STEPS; g++) begin : g_step
      localparam int Bit = arpf_pkg::SQ_STEPS - 1 - g;
      logic               vld_cur;
      arpf_pkg::side_type side_cur;
      logic [61:0]        rad_cur;
      logic [33:0]        rem_cur;
      logic [30:0]        root_cur;
      logic [35:0]        rem_t, trial, rem_in;
      logic [30:0]        root_in;

      if (g == 0) begin : g_first
         assign vld_cur  = in_valid;
         assign side_cur = in_side;
         assign rad_cur  = in_rad;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_next
         assign vld_cur  = vld_ff[g-1];
         assign side_cur = side_ff[g-1];
         assign rad_cur  = rad_ff[g-1];
         assign rem_cur  = rem_ff[g-1];
         assign root_cur = root_ff[g-1];
      end

      always_comb begin
         rem_t = {rem_cur, rad_cur[2*Bit+1 -: 2]};
         trial = {3'b000, root_cur, 2'b01};
         if (rem_t >= trial) begin
            rem_in  = rem_t - trial;
            root_in = {root_cur[29:0], 1'b1};
         end else begin
            rem_in  = rem_t;
            root_in = {root_cur[29:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_cur;
         end
         side_ff[g] <= side_cur;
         rad_ff[g]  <= rad_cur;
         rem_ff[g]  <= rem_in[33:0];
         root_ff[g] <= root_in;
      end
   end

   assign out_valid = vld_ff[arpf_pkg::SQ_STEPS-1];
   assign out_side  = side_ff[arpf_pkg::SQ_STEPS-1];
   assign out_root  = root_ff[arpf_pkg::SQ_STEPS-1];

endmodule

FILE: rtl/arpf_div.sv
// pipelined restoring divider, three lanes, gives the signed unit axis
`timescale 1ns / 1ps
module arpf_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  arpf_pkg::side_type in_side,
   input  logic [30:0]        in_norm,
   output logic               out_valid,
   output arpf_pkg::ctx_type  out_ctx,
   output logic [2:0][31:0]   out_u
);

   // prep: numerator = mag * 2^30 + norm / 2
   logic              p_vld_ff;
   arpf_pkg::ctx_type p_ctx_ff;
   logic [2:0]        p_neg_ff;
   logic [30:0]       p_norm_ff;
   logic [2:0][30:0]  p_rem_ff;
   logic [2:0][30:0]  p_lo_ff;

   always_ff @(posedge clock) begin
      logic [60:0] num;
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= in_valid;
      end
      p_ctx_ff  <= in_side.ctx;
      p_neg_ff  <= in_side.dneg;
      p_norm_ff <= in_norm;
      for (int i = 0; i < 3; i++) begin
         num = {1'b0, in_side.dmag[i], 30'b0} + 61'(in_norm[30:1]);
         p_rem_ff[i] <= {1'b0, num[60:31]};
         p_lo_ff[i]  <= num[30:0];
      end
   end

   logic              vld_ff  [arpf_pkg::DV_STEPS];
   arpf_pkg::ctx_type ctx_ff  [arpf_pkg::DV_STEPS];
   logic [2:0]        neg_ff  [arpf_pkg::DV_STEPS];
   logic [30:0]       norm_ff [arpf_pkg::DV_STEPS];
   logic [2:0][30:0]  rem_ff  [arpf_pkg::DV_STEPS];
   logic [2:0][30:0]  lo_ff   [arpf_pkg::DV_STEPS];
   logic [2:0][30:0]  quo_ff  [arpf_pkg::DV_STEPS];

   for (genvar g = 0; g < arpf_pkg::DV_STEPS; g++) begin : g_step
      localparam int Bit = arpf_pkg::DV_STEPS - 1 - g;
      logic              vld_cur;
      arpf_pkg::ctx_type ctx_cur;
      logic [2:0]        neg_cur;
      logic [30:0]       norm_cur;
      logic [2:0][30:0]  rem_cur, lo_cur, quo_cur, rem_in, quo_in;

      if (g == 0) begin : g_first
         assign vld_cur  = p_vld_ff;
         assign ctx_cur  = p_ctx_ff;
         assign neg_cur  = p_neg_ff;
         assign norm_cur = p_norm_ff;
         assign rem_cur  = p_rem_ff;
         assign lo_cur   = p_lo_ff;
         assign quo_cur  = '0;
      end else begin : g_next
         assign vld_cur  = vld_ff[g-1];
         assign ctx_cur  = ctx_ff[g-1];
         assign neg_cur  = neg_ff[g-1];
         assign norm_cur = norm_ff[g-1];
         assign rem_cur  = rem_ff[g-1];
         assign lo_cur   = lo_ff[g-1];
         assign quo_cur  = quo_ff[g-1];
      end

      always_comb begin
         logic [31:0] r2;
         for (int i = 0; i < 3; i++) begin
            r2 = {rem_cur[i], lo_cur[i][Bit]};
            if (r2 >= {1'b0, norm_cur}) begin
               rem_in[i] = 31'(r2 - {1'b0, norm_cur});
               quo_in[i] = {quo_cur[i][29:0], 1'b1};
            end else begin
               rem_in[i] = r2[30:0];
               quo_in[i] = {quo_cur[i][29:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_cur;
         end
         ctx_ff[g]  <= ctx_cur;
         neg_ff[g]  <= neg_cur;
         norm_ff[g] <= norm_cur;
         rem_ff[g]  <= rem_in;
         lo_ff[g]   <= lo_cur;
         quo_ff[g]  <= quo_in;
      end
   end

   // sign back on
   logic              f_vld_ff;
   arpf_pkg::ctx_type f_ctx_ff;
   logic [2:0][31:0]  f_u_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= vld_ff[arpf_pkg::DV_STEPS-1];
      end
      f_ctx_ff <= ctx_ff[arpf_pkg::DV_STEPS-1];
      for (int i = 0; i < 3; i++) begin
         f_u_ff[i] <= neg_ff[arpf_pkg::DV_STEPS-1][i]
                      ? -{1'b0, quo_ff[arpf_pkg::DV_STEPS-1][i]}
                      : {1'b0, quo_ff[arpf_pkg::DV_STEPS-1][i]};
      end
   end

   assign out_valid = f_vld_ff;
   assign out_ctx   = f_ctx_ff;
   assign out_u     = f_u_ff;

endmodule

FILE: rtl/arpf_rot.sv
// axial split, rodrigues rotation and saturation, one multiply rank per stage pair
`timescale 1ns / 1ps
module arpf_rot (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  arpf_pkg::ctx_type in_ctx,
   input  logic [2:0][31:0]  in_u,
   output logic              out_valid,
   output logic [31:0]       out_x,
   output logic [31:0]       out_y,
   output logic [31:0]       out_z,
   output logic              out_degen,
   output logic              out_sat
);

   // a: offset from axis start and u.w products
   logic              a_vld_ff;
   arpf_pkg::ctx_type a_ctx_ff;
   logic [2:0][31:0]  a_u_ff;
   logic [2:0][33:0]  a_w_ff;
   logic [2:0][65:0]  a_p_ff;
   // b: axial length
   logic              b_vld_ff;
   arpf_pkg::ctx_type b_ctx_ff;
   logic [2:0][31:0]  b_u_ff;
   logic [2:0][33:0]  b_w_ff;
   logic [33:0]       b_dw_ff;
   // c: axial part products
   logic              c_vld_ff;
   arpf_pkg::ctx_type c_ctx_ff;
   logic [2:0][31:0]  c_u_ff;
   logic [2:0][33:0]  c_w_ff;
   logic [2:0][65:0]  c_p_ff;
   // d: radial part, operand select
   logic              d_vld_ff;
   arpf_pkg::ctx_type d_ctx_ff;
   logic [2:0][31:0]  d_u_ff;
   logic [2:0][33:0]  d_v_ff;
   logic [2:0][39:0]  d_base_ff;
   logic [31:0]       d_s_ff;
   // e: cross and dot products
   logic              e_vld_ff;
   arpf_pkg::ctx_type e_ctx_ff;
   logic [2:0][31:0]  e_u_ff;
   logic [2:0][33:0]  e_v_ff;
   logic [2:0][39:0]  e_base_ff;
   logic [31:0]       e_s_ff;
   logic [2:0][65:0]  e_pa_ff, e_pb_ff, e_pd_ff;
   // f: u x v and u.v
   logic              f_vld_ff;
   arpf_pkg::ctx_type f_ctx_ff;
   logic [2:0][31:0]  f_u_ff;
   logic [2:0][33:0]  f_v_ff;
   logic [2:0][39:0]  f_base_ff;
   logic [31:0]       f_s_ff;
   logic [2:0][33:0]  f_cr_ff;
   logic [33:0]       f_t_ff;
   // g: cos and sin products
   logic              g_vld_ff;
   arpf_pkg::ctx_type g_ctx_ff;
   logic [2:0][31:0]  g_u_ff;
   logic [2:0][39:0]  g_base_ff;
   logic [33:0]       g_t_ff;
   logic [65:0]       g_pct_ff;
   logic [2:0][65:0]  g_pcv_ff, g_psc_ff;
   // h: k term and partial sums
   logic              h_vld_ff;
   arpf_pkg::ctx_type h_ctx_ff;
   logic [2:0][31:0]  h_u_ff;
   logic [2:0][39:0]  h_acc_ff;
   logic [33:0]       h_k_ff;
   // i: u*k products
   logic              i_vld_ff;
   arpf_pkg::ctx_type i_ctx_ff;
   logic [2:0][39:0]  i_acc_ff;
   logic [2:0][65:0]  i_p_ff;
   // j: result register
   logic              j_vld_ff;
   logic [2:0][31:0]  j_out_ff;
   logic              j_degen_ff;
   logic              j_sat_ff;

   always_ff @(posedge clock) begin
      logic signed [39:0] acc;
      logic signed [39:0] res;
      logic signed [33:0] ax_rad;
      logic               sat;
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
         i_vld_ff <= 1'b0;
         j_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
         f_vld_ff <= e_vld_ff;
         g_vld_ff <= f_vld_ff;
         h_vld_ff <= g_vld_ff;
         i_vld_ff <= h_vld_ff;
         j_vld_ff <= i_vld_ff;
      end

      // a
      a_ctx_ff <= in_ctx;
      a_u_ff   <= in_u;
      for (int i = 0; i < 3; i++) begin
         a_w_ff[i] <= 34'($signed(in_ctx.vec[i])) - 34'($signed(in_ctx.st[i]));
         a_p_ff[i] <= arpf_pkg::mulq_raw($signed(in_u[i]),
                         34'($signed(in_ctx.vec[i])) - 34'($signed(in_ctx.st[i])));
      end

      // b
      b_ctx_ff <= a_ctx_ff;
      b_u_ff   <= a_u_ff;
      b_w_ff   <= a_w_ff;
      b_dw_ff  <= arpf_pkg::clamp34(40'(arpf_pkg::rnd($signed(a_p_ff[0])))
                                  + 40'(arpf_pkg::rnd($signed(a_p_ff[1])))
                                  + 40'(arpf_pkg::rnd($signed(a_p_ff[2]))));

      // c
      c_ctx_ff <= b_ctx_ff;
      c_u_ff   <= b_u_ff;
      c_w_ff   <= b_w_ff;
      for (int i = 0; i < 3; i++) begin
         c_p_ff[i] <= arpf_pkg::mulq_raw($signed(b_u_ff[i]), $signed(b_dw_ff));
      end

      // d: place mode rotates the radial part, force mode the vector itself
      d_ctx_ff <= c_ctx_ff;
      d_u_ff   <= c_u_ff;
      d_s_ff   <= (c_ctx_ff.action == arpf_pkg::ACT_PLACE) ? c_ctx_ff.s : -c_ctx_ff.s;
      for (int i = 0; i < 3; i++) begin
         ax_rad = arpf_pkg::clamp34(40'($signed(c_w_ff[i]))
                                  - 40'(arpf_pkg::rnd($signed(c_p_ff[i]))));
         if (c_ctx_ff.action == arpf_pkg::ACT_PLACE) begin
            d_v_ff[i]    <= ax_rad;
            d_base_ff[i] <= 40'($signed(c_ctx_ff.st[i]))
                          + 40'(arpf_pkg::rnd($signed(c_p_ff[i])));
         end else begin
            d_v_ff[i]    <= 34'($signed(c_ctx_ff.vec[i]));
            d_base_ff[i] <= '0;
         end
      end

      // e
      e_ctx_ff  <= d_ctx_ff;
      e_u_ff    <= d_u_ff;
      e_v_ff    <= d_v_ff;
      e_base_ff <= d_base_ff;
      e_s_ff    <= d_s_ff;
      for (int i = 0; i < 3; i++) begin
         e_pa_ff[i] <= arpf_pkg::mulq_raw($signed(d_u_ff[(i+1)%3]), $signed(d_v_ff[(i+2)%3]));
         e_pb_ff[i] <= arpf_pkg::mulq_raw($signed(d_u_ff[(i+2)%3]), $signed(d_v_ff[(i+1)%3]));
         e_pd_ff[i] <= arpf_pkg::mulq_raw($signed(d_u_ff[i]), $signed(d_v_ff[i]));
      end

      // f
      f_ctx_ff  <= e_ctx_ff;
      f_u_ff    <= e_u_ff;
      f_v_ff    <= e_v_ff;
      f_base_ff <= e_base_ff;
      f_s_ff    <= e_s_ff;
      for (int i = 0; i < 3; i++) begin
         f_cr_ff[i] <= arpf_pkg::clamp34(40'(arpf_pkg::rnd($signed(e_pa_ff[i])))
                                       - 40'(arpf_pkg::rnd($signed(e_pb_ff[i]))));
      end
      f_t_ff <= arpf_pkg::clamp34(40'(arpf_pkg::rnd($signed(e_pd_ff[0])))
                                + 40'(arpf_pkg::rnd($signed(e_pd_ff[1])))
                                + 40'(arpf_pkg::rnd($signed(e_pd_ff[2]))));

      // g
      g_ctx_ff  <= f_ctx_ff;
      g_u_ff    <= f_u_ff;
      g_base_ff <= f_base_ff;
      g_t_ff    <= f_t_ff;
      g_pct_ff  <= arpf_pkg::mulq_raw($signed(f_ctx_ff.c), $signed(f_t_ff));
      for (int i = 0; i < 3; i++) begin
         g_pcv_ff[i] <= arpf_pkg::mulq_raw($signed(f_ctx_ff.c), $signed(f_v_ff[i]));
         g_psc_ff[i] <= arpf_pkg::mulq_raw($signed(f_s_ff), $signed(f_cr_ff[i]));
      end

      // h: k = t - round(t*cos)
      h_ctx_ff <= g_ctx_ff;
      h_u_ff   <= g_u_ff;
      h_k_ff   <= arpf_pkg::clamp34(40'($signed(g_t_ff))
                                  - 40'(arpf_pkg::rnd($signed(g_pct_ff))));
      for (int i = 0; i < 3; i++) begin
         h_acc_ff[i] <= $signed(g_base_ff[i])
                      + 40'(arpf_pkg::rnd($signed(g_pcv_ff[i])))
                      + 40'(arpf_pkg::rnd($signed(g_psc_ff[i])));
      end

      // i
      i_ctx_ff <= h_ctx_ff;
      i_acc_ff <= h_acc_ff;
      for (int i = 0; i < 3; i++) begin
         i_p_ff[i] <= arpf_pkg::mulq_raw($signed(h_u_ff[i]), $signed(h_k_ff));
      end

      // j: final sum and clamp to int32, zero for a degenerate axis
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = $signed(i_acc_ff[i]);
         res = acc + 40'(arpf_pkg::rnd($signed(i_p_ff[i])));
         if (i_ctx_ff.degen) begin
            j_out_ff[i] <= '0;
         end else if (res > arpf_pkg::OUT_MAX) begin
            j_out_ff[i] <= arpf_pkg::OUT_MAX[31:0];
            sat = 1'b1;
         end else if (res < arpf_pkg::OUT_MIN) begin
            j_out_ff[i] <= arpf_pkg::OUT_MIN[31:0];
            sat = 1'b1;
         end else begin
            j_out_ff[i] <= res[31:0];
         end
      end
      j_degen_ff <= i_ctx_ff.degen;
      j_sat_ff   <= sat & ~i_ctx_ff.degen;
   end

   assign out_valid = j_vld_ff;
   assign out_x     = j_out_ff[0];
   assign out_y     = j_out_ff[1];
   assign out_z     = j_out_ff[2];
   assign out_degen = j_degen_ff;
   assign out_sat   = j_sat_ff;

endmodule

FILE: rtl/axis_rotation_place_and_force.sv
// top level: rotation of a point or a force about an axis through two points
`timescale 1ns / 1ps
//
//  channel   ports                       handshake
//  --------  --------------------------  ------------------------------------
//  request   req_*, start, busy          item taken when start & !busy
//  response  rsp_*, rsp_valid            one-cycle strobe, cannot be held off
//
// fully pipelined, one item per clock; busy is never raised
// the pipe is an input register, 4 scaling stages, 31 square root
// stages, 33 divider stages (prep, 31 quotient bits, sign) and 10 rotation stages
// the square root and the divider each resolve one bit per stage and set the depth
// synchronous reset clears only the valid bits of the pipe
//
module axis_rotation_place_and_force (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [31:0] req_axis_start_x,
   input  logic [31:0] req_axis_start_y,
   input  logic [31:0] req_axis_start_z,
   input  logic [31:0] req_axis_end_x,
   input  logic [31:0] req_axis_end_y,
   input  logic [31:0] req_axis_end_z,
   input  logic [31:0] req_vec_x,
   input  logic [31:0] req_vec_y,
   input  logic [31:0] req_vec_z,
   input  logic [31:0] req_cosine,
   input  logic [31:0] req_sine,
   output logic        rsp_valid,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic        rsp_axis_degenerate,
   output logic        rsp_saturated
);

   // nothing ever back-pressures the pipe
   assign busy = 1'b0;

   // input register
   logic              in_vld_ff;
   arpf_pkg::ctx_type in_ctx_ff, in_ctx_in;
   logic [2:0][31:0]  in_end_ff;

   always_comb begin
      in_ctx_in.action = req_action;
      in_ctx_in.degen  = 1'b0;          // filled in by the scaling stage
      in_ctx_in.st     = {req_axis_start_z, req_axis_start_y, req_axis_start_x};
      in_ctx_in.vec    = {req_vec_z, req_vec_y, req_vec_x};
      in_ctx_in.c      = req_cosine;
      in_ctx_in.s      = req_sine;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start & ~busy;
      end
      in_ctx_ff <= in_ctx_in;
      in_end_ff <= {req_axis_end_z, req_axis_end_y, req_axis_end_x};
   end

   // axis scaling and sum of squares
   logic               nrm_vld;
   arpf_pkg::side_type nrm_side;
   logic [61:0]        nrm_sum;

   arpf_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_vld_ff),
      .in_ctx    (in_ctx_ff),
      .in_end    (in_end_ff),
      .out_valid (nrm_vld),
      .out_side  (nrm_side),
      .out_sum   (nrm_sum)
   );

   // axis length
   logic               sq_vld;
   arpf_pkg::side_type sq_side;
   logic [30:0]        sq_root;

   arpf_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (nrm_vld),
      .in_side   (nrm_side),
      .in_rad    (nrm_sum),
      .out_valid (sq_vld),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   // unit axis in q2.30
   logic              dv_vld;
   arpf_pkg::ctx_type dv_ctx;
   logic [2:0][31:0]  dv_u;

   arpf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_vld),
      .in_side   (sq_side),
      .in_norm   (sq_root),
      .out_valid (dv_vld),
      .out_ctx   (dv_ctx),
      .out_u     (dv_u)
   );

   // rotation and output register
   arpf_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_vld),
      .in_ctx    (dv_ctx),
      .in_u      (dv_u),
      .out_valid (rsp_valid),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z),
      .out_degen (rsp_axis_degenerate),
      .out_sat   (rsp_saturated)
   );

endmodule

FILE: tb/sv/tb_axis_rotation_place_and_force.sv
// testbench for the axis rotation block: directed and random items checked against a predictor
`timescale 1ns / 1ps
module tb_axis_rotation_place_and_force;

   localparam longint Q30      = 64'sd1073741824;
   localparam longint LIM33    = 64'sd8589934591;
   localparam int     LATENCY  = 79;

   // one request item as driven on the req_ ports
   typedef struct {
      arpf_pkg::action_type action;
      logic [2:0][31:0]     ax_s;
      logic [2:0][31:0]     ax_e;
      logic [2:0][31:0]     vec;
      logic [31:0]          cosv;
      logic [31:0]          sinv;
   } rot_item_type;

   // one rotated result
   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        degen;
      logic        sat;
   } rot_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_action = 1'b0;
   logic [31:0] req_axis_start_x = '0, req_axis_start_y = '0, req_axis_start_z = '0;
   logic [31:0] req_axis_end_x = '0, req_axis_end_y = '0, req_axis_end_z = '0;
   logic [31:0] req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic [31:0] req_cosine = '0, req_sine = '0;
   logic        rsp_valid;
   logic [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic        rsp_axis_degenerate, rsp_saturated;

   rot_result_type expected_rotations[$];
   int             mismatch_count = 0;
   bit             no_idle = 1'b0;

   always #6 clock = ~clock;

   axis_rotation_place_and_force dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action),
      .req_axis_start_x(req_axis_start_x), .req_axis_start_y(req_axis_start_y),
      .req_axis_start_z(req_axis_start_z),
      .req_axis_end_x(req_axis_end_x), .req_axis_end_y(req_axis_end_y),
      .req_axis_end_z(req_axis_end_z),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y), .req_vec_z(req_vec_z),
      .req_cosine(req_cosine), .req_sine(req_sine),
      .rsp_valid(rsp_valid), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z), .rsp_axis_degenerate(rsp_axis_degenerate),
      .rsp_saturated(rsp_saturated)
   );

   // ---------------------------------------------------------------- predictor

   // q2.30 times q16.16, rounded half up back to q16.16
   function automatic longint mul_round(input longint a, input longint b);
      return (a * b + 64'sd536870912) >>> 30;
   endfunction

   function automatic longint clamp_sym(input longint x, input longint lim);
      if (x > lim) begin
         return lim;
      end
      if (x < -lim) begin
         return -lim;
      end
      return x;
   endfunction

   function automatic longint abs64(input longint x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) begin
         b = b >> 2;
      end
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // rodrigues: v*c + (u x v)*s + u*(u.v)*(1-c)
   function automatic void rodrigues(input longint u[3], input longint v[3], input longint c,
                                     input longint s, output longint r[3]);
      longint cr[3];
      longint t;
      longint k;
      cr[0] = clamp_sym(mul_round(u[1], v[2]) - mul_round(u[2], v[1]), LIM33);
      cr[1] = clamp_sym(mul_round(u[2], v[0]) - mul_round(u[0], v[2]), LIM33);
      cr[2] = clamp_sym(mul_round(u[0], v[1]) - mul_round(u[1], v[0]), LIM33);
      t = clamp_sym(mul_round(u[0], v[0]) + mul_round(u[1], v[1]) + mul_round(u[2], v[2]),
                    LIM33);
      k = clamp_sym(t - mul_round(c, t), LIM33);
      for (int i = 0; i < 3; i++) begin
         r[i] = mul_round(c, v[i]) + mul_round(s, cr[i]) + mul_round(u[i], k);
      end
   endfunction

   function automatic rot_result_type predict_rotation(input rot_item_type it);
      rot_result_type   res;
      longint           st[3], d[3], v[3], u[3], w[3], ax[3], rad[3], rot[3], fin[3];
      longint           c, s, m, dw, lo;
      longint unsigned  sum, norm, q;
      int               sh;
      logic [2:0][31:0] outs;
      m = 0;
      for (int i = 0; i < 3; i++) begin
         st[i] = longint'($signed(it.ax_s[i]));
         d[i]  = longint'($signed(it.ax_e[i])) - st[i];
         v[i]  = longint'($signed(it.vec[i]));
         if (abs64(d[i]) > m) begin
            m = abs64(d[i]);
         end
      end
      c = clamp_sym(longint'($signed(it.cosv)), Q30);
      s = clamp_sym(longint'($signed(it.sinv)), Q30);
      res = '{x: '0, y: '0, z: '0, degen: 1'b1, sat: 1'b0};
      if (m == 0) begin
         return res;
      end
      // normalize the largest component into [2^29, 2^30)
      sh = 0;
      if (m >= Q30) begin
         while ((m >> sh) >= Q30) begin
            sh++;
         end
         for (int i = 0; i < 3; i++) begin
            d[i] = (d[i] < 0) ? -(abs64(d[i]) >> sh) : (d[i] >> sh);
         end
      end else begin
         while ((m << sh) < (Q30 >> 1)) begin
            sh++;
         end
         for (int i = 0; i < 3; i++) begin
            d[i] = d[i] << sh;
         end
      end
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         sum += longint'(d[i] * d[i]);
      end
      norm = floor_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (longint'(abs64(d[i])) * Q30 + norm / 2) / norm;
         u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
      end
      if (it.action == arpf_pkg::ACT_PLACE) begin
         for (int i = 0; i < 3; i++) begin
            w[i] = v[i] - st[i];
         end
         dw = clamp_sym(mul_round(u[0], w[0]) + mul_round(u[1], w[1]) + mul_round(u[2], w[2]),
                        LIM33);
         for (int i = 0; i < 3; i++) begin
            ax[i]  = mul_round(u[i], dw);
            rad[i] = clamp_sym(w[i] - ax[i], LIM33);
         end
         rodrigues(u, rad, c, s, rot);
         for (int i = 0; i < 3; i++) begin
            fin[i] = st[i] + ax[i] + rot[i];
         end
      end else begin
         rodrigues(u, v, c, -s, fin);
      end
      lo = -64'sd2147483648;
      for (int i = 0; i < 3; i++) begin
         if (fin[i] > 64'sd2147483647) begin
            fin[i] = 64'sd2147483647;
            res.sat = 1'b1;
         end
         if (fin[i] < lo) begin
            fin[i] = lo;
            res.sat = 1'b1;
         end
         outs[i] = fin[i][31:0];
      end
      res.x = outs[0];
      res.y = outs[1];
      res.z = outs[2];
      res.degen = 1'b0;
      return res;
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_item(input rot_item_type it);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      req_action       <= it.action;
      req_axis_start_x <= it.ax_s[0];
      req_axis_start_y <= it.ax_s[1];
      req_axis_start_z <= it.ax_s[2];
      req_axis_end_x   <= it.ax_e[0];
      req_axis_end_y   <= it.ax_e[1];
      req_axis_end_z   <= it.ax_e[2];
      req_vec_x        <= it.vec[0];
      req_vec_y        <= it.vec[1];
      req_vec_z        <= it.vec[2];
      req_cosine       <= it.cosv;
      req_sine         <= it.sinv;
      start            <= 1'b1;
      // busy is sampled before the edge updates it
      do begin
         @(posedge clock);
      end while (busy);
      expected_rotations.push_back(predict_rotation(it));
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t ns: %s got %h want %h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      rot_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_rotations.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_out_x, '0);
         end else begin
            want = expected_rotations.pop_front();
            if (rsp_out_x !== want.x) report_mismatch("out_x", rsp_out_x, want.x);
            if (rsp_out_y !== want.y) report_mismatch("out_y", rsp_out_y, want.y);
            if (rsp_out_z !== want.z) report_mismatch("out_z", rsp_out_z, want.z);
            if (rsp_axis_degenerate !== want.degen) begin
               report_mismatch("axis_degenerate", 32'(rsp_axis_degenerate), 32'(want.degen));
            end
            if (rsp_saturated !== want.sat) begin
               report_mismatch("saturated", 32'(rsp_saturated), 32'(want.sat));
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   // coordinate: moderate values half the time, otherwise full range or an extreme
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h7fff_ffff;
         2: return 32'h8000_0000;
         3: return 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
         default: return 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
      endcase
   endfunction

   function automatic logic [31:0] angle_q30(input real a, input bit want_sine);
      real r;
      r = want_sine ? $sin(a) : $cos(a);
      return 32'(longint'(r * 1073741824.0));
   endfunction

   function automatic rot_item_type rand_item(input arpf_pkg::action_type act);
      rot_item_type it;
      real          a;
      it.action = act;
      for (int i = 0; i < 3; i++) begin
         it.ax_s[i] = rand_coord();
         it.vec[i]  = rand_coord();
         case ($urandom_range(0, 5))
            // tiny axis exercises the left-shift normalization
            0: it.ax_e[i] = it.ax_s[i] + 32'($urandom_range(0, 16)) - 32'd8;
            1: it.ax_e[i] = it.ax_s[i];
            2: it.ax_e[i] = $urandom;
            default: it.ax_e[i] = it.ax_s[i] + 32'($urandom_range(0, 32'h0400_0000))
                                  - 32'h0200_0000;
         endcase
      end
      // occasionally a fully degenerate axis
      if ($urandom_range(0, 30) == 0) begin
         it.ax_e = it.ax_s;
      end
      a = ($urandom_range(0, 62831) / 10000.0);
      it.cosv = angle_q30(a, 1'b0);
      it.sinv = angle_q30(a, 1'b1);
      // raw trig values hit the clamp and toggle every bit
      if ($urandom_range(0, 9) == 0) it.cosv = $urandom;
      if ($urandom_range(0, 9) == 0) it.sinv = $urandom;
      return it;
   endfunction

   function automatic rot_item_type make_item(input arpf_pkg::action_type act,
                                              input logic [31:0] s_c,
                                              input logic [31:0] e_c, input logic [31:0] v_c,
                                              input logic [31:0] c, input logic [31:0] s);
      rot_item_type it;
      it.action = act;
      for (int i = 0; i < 3; i++) begin
         it.ax_s[i] = s_c;
         it.vec[i]  = v_c;
         it.ax_e[i] = (i == 2) ? e_c : s_c;
      end
      it.cosv = c;
      it.sinv = s;
      return it;
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      rot_item_type it;
      // quarter turn about z, both operations
      send_item(make_item(arpf_pkg::ACT_PLACE, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0,
                          32'h4000_0000));
      send_item(make_item(arpf_pkg::ACT_FORCE, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0,
                          32'h4000_0000));
      // identity and half turn
      send_item(make_item(arpf_pkg::ACT_PLACE, 32'h0001_0000, 32'h0005_0000, 32'h0003_0000,
                          32'h4000_0000, 32'h0));
      send_item(make_item(arpf_pkg::ACT_FORCE, 32'h0, 32'hfffe_0000, 32'h0002_8000,
                          32'hc000_0000, 32'h0));
      // degenerate axis in both operations
      send_item(make_item(arpf_pkg::ACT_PLACE, 32'h1234_5678, 32'h1234_5678, 32'h0001_0000,
                          32'h4000_0000, 32'h0));
      send_item(make_item(arpf_pkg::ACT_FORCE, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                          32'h0, 32'h4000_0000));
      // axis spanning the whole range needs the right shift
      send_item(make_item(arpf_pkg::ACT_PLACE, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h2d41_3ccd, 32'h2d41_3ccd));
      send_item(make_item(arpf_pkg::ACT_FORCE, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                          32'h2d41_3ccd, 32'hd2be_c333));
      // one-lsb axis needs the largest left shift
      send_item(make_item(arpf_pkg::ACT_PLACE, 32'h0, 32'h1, 32'h7fff_ffff, 32'h0,
                          32'hc000_0000));
      send_item(make_item(arpf_pkg::ACT_FORCE, 32'hffff_ffff, 32'h0, 32'h8000_0000, 32'h0,
                          32'h4000_0000));
      // trig out of range, clamped
      send_item(make_item(arpf_pkg::ACT_PLACE, 32'h0, 32'h0001_0000, 32'h0001_0000,
                          32'h7fff_ffff, 32'h8000_0000));
      send_item(make_item(arpf_pkg::ACT_FORCE, 32'h0, 32'h0001_0000, 32'h0001_0000,
                          32'h8000_0000, 32'h7fff_ffff));
      send_item(make_item(arpf_pkg::ACT_FORCE, 32'h0, 32'h0001_0000, 32'h0001_0000,
                          32'h4000_0001, 32'hbfff_ffff));
      // saturation at both ends with a skew axis
      it = make_item(arpf_pkg::ACT_PLACE, 32'h0, 32'h0, 32'h7fff_ffff, 32'h0, 32'h4000_0000);
      it.ax_e[0] = 32'h0001_0000;
      it.ax_e[1] = 32'h0001_0000;
      send_item(it);
      it.vec[0] = 32'h8000_0000;
      it.action = arpf_pkg::ACT_FORCE;
      send_item(it);
      // far-away start with a huge offset in place mode
      it = make_item(arpf_pkg::ACT_PLACE, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                     32'hc000_0000, 32'h0);
      it.ax_e[0] = 32'h8000_0001;
      send_item(it);
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) begin
         // stretches of back-to-back items between idling stretches
         if (n % 64 == 0) begin
            no_idle = ($urandom_range(0, 3) == 0);
         end
         send_item(rand_item($urandom_range(0, 1) ? arpf_pkg::ACT_FORCE : arpf_pkg::ACT_PLACE));
      end
      no_idle = 1'b0;
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      @(negedge clock);
      start <= 1'b0;
      while (expected_rotations.size() != 0 && waited < 20 * LATENCY) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1035);
      drain_results();
      if (mismatch_count == 0 && expected_rotations.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: sim.f
rtl/arpf_pkg.sv
rtl/arpf_norm.sv
rtl/arpf_sqrt.sv
rtl/arpf_div.sv
rtl/arpf_rot.sv
rtl/axis_rotation_place_and_force.sv
tb/sv/tb_axis_rotation_place_and_force.sv
